/* hdl/pmr_pkg.sv */
`default_nettype none
package pmr_pkg;

    // Field widths of one descriptor beat
    localparam int SOURCE_W = 6;
    localparam int COUNT_W  = 16;
    localparam int BUF_W    = 4;
    localparam int LEN_W    = 24;

    // Number of distinct source codes the source field can carry
    localparam int SRC_RANGE = 2 ** SOURCE_W;

    // Defaults for the top-level parameters
    localparam int NUM_SOURCES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef struct packed {
        logic [SOURCE_W-1:0] source;
        logic [COUNT_W-1:0]  seq_count;
        logic                ordered;
        logic [BUF_W-1:0]    buffer_index;
        logic [LEN_W-1:0]    msg_length;
    } t_in_item;

    typedef struct packed {
        logic [BUF_W-1:0]    out_buffer;
        logic [SOURCE_W-1:0] out_source;
        logic [LEN_W-1:0]    out_length;
        logic                overflow;
        logic                last;
    } t_out_item;

    // Payload of a parked message (its count lives in the tag cells)
    typedef struct packed {
        logic [SOURCE_W-1:0] source;
        logic [BUF_W-1:0]    buffer_index;
        logic [LEN_W-1:0]    msg_length;
    } t_wait_data;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_PICK,
        ST_LOAD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch descriptor, read its expected count
        logic emit_item;  // deliver descriptor as the only result
        logic hold_item;  // deliver descriptor later, bump count, start release
        logic drop_item;  // queue full: report overflow
        logic park_item;  // store descriptor in the wait queue
        logic scan;       // compare all queue tags against expected count
        logic take_entry; // emit pending result, take matching entry
        logic finish;     // emit pending result as last, write count back
        logic load;       // pending result from released entry
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic deliver;
        logic ordered;
        logic full;
        logic hit;
    } t_stat;

endpackage
`default_nettype wire

/* hdl/pmr_ctrl.sv */
`default_nettype none
module pmr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pmr_pkg::t_stat i_stat,
    output pmr_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import pmr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (i_stat.deliver && i_stat.ordered) n_state = ST_SCAN;
                else n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (i_stat.hit) n_state = ST_LOAD;
                else n_state = ST_IDLE;
            end
            ST_LOAD: begin
                n_state = ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
            end
            ST_LOOKUP: begin
                if (i_stat.deliver) begin
                    o_cmd.hold_item = i_stat.ordered;
                    o_cmd.emit_item = !i_stat.ordered;
                end else begin
                    o_cmd.drop_item = i_stat.full;
                    o_cmd.park_item = !i_stat.full;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_PICK: begin
                o_cmd.take_entry = i_stat.hit;
                o_cmd.finish     = !i_stat.hit;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* hdl/pmr_datapath.sv */
`default_nettype none
module pmr_datapath #(
    parameter int NUM_SOURCES = pmr_pkg::NUM_SOURCES_DEF,
    parameter int QUEUE_DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pmr_pkg::t_in_item i_item,
    input  wire pmr_pkg::t_cmd     i_cmd,
    output pmr_pkg::t_stat         o_stat,
    output pmr_pkg::t_out_item     o_result,
    output logic                   o_valid
);
    import pmr_pkg::*;

    // Only slots reachable from the source field need a counter
    localparam int CNT_DEPTH = (NUM_SOURCES < SRC_RANGE) ? NUM_SOURCES : SRC_RANGE;
    localparam int SLOT_W    = $clog2(CNT_DEPTH);
    localparam int QIDX_W    = $clog2(QUEUE_DEPTH);

    // Source to counter slot fold, a constant table
    logic [SLOT_W-1:0] w_fold_tab [SRC_RANGE];
    for (genvar g = 0; g < SRC_RANGE; g++) begin : g_fold
        assign w_fold_tab[g] = SLOT_W'(g % NUM_SOURCES);
    end

    // Descriptor and expected count
    t_in_item          r_item;
    logic [SLOT_W-1:0] r_slot;
    logic [COUNT_W-1:0] r_exp;
    logic [COUNT_W-1:0] w_exp_cur;

    // Expected-count memory with per-slot written flags
    logic [COUNT_W-1:0]   r_cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0] r_cnt_vld;
    logic [COUNT_W-1:0]   r_cnt_rd;
    logic                 r_cnt_rd_vld;

    // Wait queue: tag cells, valid bits, payload memory
    logic [QUEUE_DEPTH-1:0] r_q_vld;
    logic [SLOT_W-1:0]      r_q_slot [QUEUE_DEPTH];
    logic [COUNT_W-1:0]     r_q_cnt  [QUEUE_DEPTH];
    t_wait_data             r_q_mem  [QUEUE_DEPTH];
    t_wait_data             r_q_rd;
    logic [QUEUE_DEPTH-1:0] r_match;
    logic [QIDX_W-1:0]      w_pick_idx;
    logic [QIDX_W-1:0]      w_free_idx;
    logic [QIDX_W-1:0]      r_free_idx;
    logic                   r_full;

    // Pending delivery and output register
    t_wait_data r_pend;
    t_out_item  r_out;
    logic       r_out_vld;

    // Descriptor capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
            r_slot <= w_fold_tab[i_item.source];
        end
    end

    // Counter memory: read on accept, write back at end of release
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt_rd <= r_cnt_mem[w_fold_tab[i_item.source]];
        end
        if (i_cmd.finish) begin
            r_cnt_mem[r_slot] <= r_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld    <= '0;
            r_cnt_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) r_cnt_rd_vld <= r_cnt_vld[w_fold_tab[i_item.source]];
            if (i_cmd.finish) r_cnt_vld[r_slot] <= 1'b1;
        end
    end

    // A never-written slot counts from zero
    assign w_exp_cur = r_cnt_rd_vld ? r_cnt_rd : '0;

    // Running expected count during release
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_item) begin
            r_exp <= w_exp_cur + COUNT_W'(1);
        end else if (i_cmd.take_entry) begin
            r_exp <= r_exp + COUNT_W'(1);
        end
    end

    // Lowest free queue entry, registered; valid bits settle well before use
    always_comb begin
        w_free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_q_vld[i]) w_free_idx = QIDX_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= w_free_idx;
        r_full     <= &r_q_vld;
    end

    // Lowest matching entry
    always_comb begin
        w_pick_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) w_pick_idx = QIDX_W'(i);
        end
    end

    // Queue valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= '0;
        end else begin
            if (i_cmd.park_item)  r_q_vld[r_free_idx] <= 1'b1;
            if (i_cmd.take_entry) r_q_vld[w_pick_idx] <= 1'b0;
        end
    end

    // Tag cells and parallel match
    always_ff @(posedge i_clk) begin
        if (i_cmd.park_item) begin
            r_q_slot[r_free_idx] <= r_slot;
            r_q_cnt[r_free_idx]  <= r_item.seq_count;
        end
        if (i_cmd.scan) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_match[i] <= r_q_vld[i] && (r_q_slot[i] == r_slot) && (r_q_cnt[i] == r_exp);
            end
        end
    end

    // Payload memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.park_item) begin
            r_q_mem[r_free_idx] <= '{source: r_item.source,
                                     buffer_index: r_item.buffer_index,
                                     msg_length: r_item.msg_length};
        end
        if (i_cmd.take_entry) begin
            r_q_rd <= r_q_mem[w_pick_idx];
        end
    end

    // Pending result, delivered once the next step is known
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_item) begin
            r_pend <= '{source: r_item.source,
                        buffer_index: r_item.buffer_index,
                        msg_length: r_item.msg_length};
        end else if (i_cmd.load) begin
            r_pend <= r_q_rd;
        end
    end

    // Output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_item || i_cmd.drop_item) begin
            r_out <= '{out_buffer: r_item.buffer_index, out_source: r_item.source,
                       out_length: r_item.msg_length, overflow: i_cmd.drop_item,
                       last: 1'b1};
        end else if (i_cmd.take_entry || i_cmd.finish) begin
            r_out <= '{out_buffer: r_pend.buffer_index, out_source: r_pend.source,
                       out_length: r_pend.msg_length, overflow: 1'b0,
                       last: i_cmd.finish};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_item | i_cmd.drop_item | i_cmd.take_entry | i_cmd.finish;
        end
    end

    // Status
    assign o_stat.deliver = !r_item.ordered || (r_item.seq_count == w_exp_cur);
    assign o_stat.ordered = r_item.ordered;
    assign o_stat.full    = r_full;
    assign o_stat.hit     = |r_match;

    assign o_result = r_out;
    assign o_valid  = r_out_vld;

endmodule
`default_nettype wire

/* hdl/per_source_message_reorder.sv */
// An unordered, parked or dropped descriptor is decided in the lookup state; an
// in-order delivery is held and emitted from the release loop (tag scan, pick,
// payload memory read), followed by each released queued message in turn.
// A new descriptor is taken only in the idle state, once any release is done.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset (synchronous): counters read as zero, wait queue empty, no clearing pass.
`default_nettype none
module per_source_message_reorder #(
    parameter int NUM_SOURCES = pmr_pkg::NUM_SOURCES_DEF,
    parameter int QUEUE_DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pmr_pkg::t_in_item i_item,
    output logic                   o_busy,
    output logic                   o_valid,
    output pmr_pkg::t_out_item     o_result
);
    import pmr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    pmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // Counters, wait queue and output beat
    pmr_datapath #(
        .NUM_SOURCES (NUM_SOURCES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule
`default_nettype wire
